@@ src/translation_table_walker_core_assert.svh @@
// Assertion macros for the translation table walker core.
`ifndef TRANSLATION_TABLE_WALKER_CORE_ASSERT_SVH
`define TRANSLATION_TABLE_WALKER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Checked on every clk edge outside of reset.
`define TTW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every clk edge, reset included.
`define TTW_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TTW_ASSERT(label, prop, msg)
`define TTW_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

@@ src/ttw_pkg.sv @@
// Shared types, codes and address helpers for the translation table walker.
package ttw_pkg;

  localparam int PaBits   = 48;
  localparam int VaBits   = 64;
  localparam int DescBits = 64;

  typedef enum logic {
    REQ_START = 1'b0,
    REQ_DESC  = 1'b1
  } req_type_t;

  typedef enum logic [1:0] {
    KIND_READ    = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_FAULT   = 2'd2,
    KIND_IGNORED = 2'd3
  } kind_t;

  localparam logic [1:0] CFG_GRANULE = 2'd0;
  localparam logic [1:0] CFG_LEVELS  = 2'd1;
  localparam logic [1:0] CFG_ROOT    = 2'd2;

  localparam logic [1:0] GRAN_16K = 2'd1;
  localparam logic [1:0] GRAN_64K = 2'd2;

  localparam logic [1:0] DESC_TABLE = 2'b11;
  localparam logic [1:0] DESC_BLOCK = 2'b01;

  typedef struct packed {
    logic [1:0]        granule_code;
    logic [2:0]        level_count;
    logic [PaBits-1:0] root_table_base;
  } cfg_t;

  typedef struct packed {
    req_type_t           req_type;
    logic [VaBits-1:0]   virt_addr;
    logic [DescBits-1:0] descriptor;
  } item_t;

  typedef struct packed {
    kind_t             result_kind;
    logic [PaBits-1:0] paddr;
    logic [1:0]        level;
    logic              is_block;
  } result_t;

  // Bits of VA resolved per level (page shift minus 3); reserved code acts as 4K.
  function automatic logic [3:0] bits_per_level(logic [1:0] g);
    logic [3:0] s;
    case (g)
      GRAN_16K: s = 4'd11;
      GRAN_64K: s = 4'd13;
      default:  s = 4'd9;
    endcase
    return s;
  endfunction

  // Starting level; out-of-range counts clamp to 1..4.
  function automatic logic [1:0] first_level(logic [2:0] n);
    logic [1:0] l;
    case (n)
      3'd0, 3'd1: l = 2'd3;
      3'd2:       l = 2'd2;
      3'd3:       l = 2'd1;
      default:    l = 2'd0;
    endcase
    return l;
  endfunction

  // Low bit of the VA index field at a level: s * (4 - lvl) + 3, at most 55.
  function automatic logic [5:0] index_shift(logic [1:0] g, logic [1:0] lvl);
    logic [5:0] s;
    logic [5:0] steps;
    s     = {2'b00, bits_per_level(g)};
    steps = 6'd4 - {4'b0000, lvl};
    return s * steps + 6'd3;
  endfunction

  // Address of the entry for vaddr in the table at base, wrapping at 48 bits.
  function automatic logic [PaBits-1:0] entry_addr(logic [PaBits-1:0] base,
                                                   logic [VaBits-1:0] vaddr,
                                                   logic [1:0] g, logic [1:0] lvl);
    logic [VaBits-1:0] sh;
    logic [12:0]       mask;
    logic [12:0]       idx;
    sh = vaddr >> index_shift(g, lvl);
    case (g)
      GRAN_16K: mask = 13'h07ff;
      GRAN_64K: mask = 13'h1fff;
      default:  mask = 13'h01ff;
    endcase
    idx = sh[12:0] & mask;
    return base + PaBits'({idx, 3'b000});
  endfunction

  // Next-level table base: descriptor bits 47 down to the page shift.
  function automatic logic [PaBits-1:0] table_base(logic [DescBits-1:0] desc,
                                                   logic [1:0] g);
    logic [PaBits-1:0] m;
    case (g)
      GRAN_16K: m = {{(PaBits-14){1'b1}}, 14'd0};
      GRAN_64K: m = {{(PaBits-16){1'b1}}, 16'd0};
      default:  m = {{(PaBits-12){1'b1}}, 12'd0};
    endcase
    return desc[PaBits-1:0] & m;
  endfunction

endpackage

@@ src/ttw_in_reg.sv @@
// Input register stage of the translation table walker.
module ttw_in_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  ttw_pkg::item_t load_item,
  input  logic          take,
  output logic          item_valid,
  output ttw_pkg::item_t item
);

  logic           valid_r, valid_nxt;
  ttw_pkg::item_t item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (take) valid_nxt = 1'b0;
    if (load) valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) item_r <= load_item;
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

@@ src/ttw_walk.sv @@
// Walk state, descriptor decode and result register.
`include "translation_table_walker_core_assert.svh"

module ttw_walk (
  input  logic             clk,
  input  logic             rst_n,
  input  ttw_pkg::cfg_t    cfg,
  input  logic             item_valid,
  input  ttw_pkg::item_t   item,
  output logic             take,
  output logic             res_valid,
  input  logic             res_ready,
  output ttw_pkg::result_t res
);

  logic                           busy_r, busy_nxt;
  logic [1:0]                     level_r, level_nxt;
  logic [ttw_pkg::VaBits-1:0]     vaddr_r, vaddr_nxt;
  logic [ttw_pkg::PaBits-1:0]     entry_r, entry_nxt;
  logic                           res_valid_r, res_valid_nxt;
  ttw_pkg::result_t               res_r, res_nxt;
  logic [1:0]                     dtype;
  logic [1:0]                     lvl_next;

  assign take     = item_valid && (!res_valid_r || res_ready);
  assign dtype    = item.descriptor[1:0];
  assign lvl_next = level_r + 2'd1;

  always_comb begin
    busy_nxt  = busy_r;
    level_nxt = level_r;
    vaddr_nxt = vaddr_r;
    entry_nxt = entry_r;
    res_nxt   = '{result_kind: ttw_pkg::KIND_IGNORED, paddr: '0,
                  level: 2'd0, is_block: 1'b0};
    if (item.req_type == ttw_pkg::REQ_START) begin
      level_nxt = ttw_pkg::first_level(cfg.level_count);
      vaddr_nxt = item.virt_addr;
      entry_nxt = ttw_pkg::entry_addr(cfg.root_table_base, item.virt_addr,
                                      cfg.granule_code, level_nxt);
      busy_nxt  = 1'b1;
      res_nxt   = '{result_kind: ttw_pkg::KIND_READ, paddr: entry_nxt,
                    level: level_nxt, is_block: 1'b0};
    end else if (busy_r) begin
      res_nxt = '{result_kind: ttw_pkg::KIND_FAULT, paddr: entry_r,
                  level: level_r, is_block: 1'b0};
      busy_nxt = 1'b0;
      if (dtype == ttw_pkg::DESC_TABLE) begin
        if (level_r == 2'd3) begin
          res_nxt.result_kind = ttw_pkg::KIND_DONE;
        end else begin
          busy_nxt  = 1'b1;
          level_nxt = lvl_next;
          entry_nxt = ttw_pkg::entry_addr(
                        ttw_pkg::table_base(item.descriptor, cfg.granule_code),
                        vaddr_r, cfg.granule_code, lvl_next);
          res_nxt   = '{result_kind: ttw_pkg::KIND_READ, paddr: entry_nxt,
                        level: lvl_next, is_block: 1'b0};
        end
      end else if (dtype == ttw_pkg::DESC_BLOCK) begin
        res_nxt.result_kind = ttw_pkg::KIND_DONE;
        res_nxt.is_block    = 1'b1;
      end
    end
  end

  always_comb begin
    res_valid_nxt = res_valid_r;
    if (res_ready) res_valid_nxt = 1'b0;
    if (take)      res_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      level_r     <= 2'd0;
      vaddr_r     <= '0;
      entry_r     <= '0;
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= res_valid_nxt;
      if (take) begin
        busy_r  <= busy_nxt;
        level_r <= level_nxt;
        vaddr_r <= vaddr_nxt;
        entry_r <= entry_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) res_r <= res_nxt;
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

  `TTW_ASSERT(a_start_sets_busy, take && item.req_type == ttw_pkg::REQ_START |=> busy_r, "walk not busy after a start")
  `TTW_ASSERT(a_table_done_last, res_valid_r && res_r.result_kind == ttw_pkg::KIND_DONE && !res_r.is_block |-> res_r.level == 2'd3, "table descriptor ended walk above last level")
  `TTW_ASSERT(a_ignored_idle, take && item.req_type == ttw_pkg::REQ_DESC && !busy_r |=> res_r.result_kind == ttw_pkg::KIND_IGNORED && res_r.paddr == '0 && !busy_r, "idle descriptor not ignored")
  `TTW_ASSERT(a_read_not_block, res_valid_r && res_r.result_kind == ttw_pkg::KIND_READ |-> !res_r.is_block && busy_r, "read request without an active walk")

endmodule

@@ src/translation_table_walker_core.sv @@
// Top level of the translation table walker core.
// Translation table walker: walks a 64-bit multi-level translation table with a
// 4K, 16K or 64K granule and 1 to 4 levels. A start transfer (tuser 0) carries a
// virtual address and yields a read request for the first descriptor, at level
// 4 - level_count in the table at root_table_base. Each descriptor transfer
// (tuser 1) yields exactly one result: a read request for the next level
// (table descriptor), done (block descriptor, or table descriptor at level 3),
// or fault (any other type); a descriptor with no walk in progress yields kind
// "ignored" with zero address. A start during a walk restarts it. Rate: one
// transfer per cycle sustained while the result is not stalled; each item
// passes the input register, then decode and address add into the result
// register. Output back-pressure passes straight to in_tready, so a stalled
// result holds up the input only once both registers are full. Config writes
// are always accepted and belong in idle periods.
module translation_table_walker_core (
  input  logic         clk,
  input  logic         rst_n,
  // input stream
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // [63:0] virt_addr, [127:64] descriptor
  input  logic         in_tuser,   // [0] req_type
  // result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [55:0]  out_tdata,  // [47:0] paddr, [49:48] level, [50] is_block, rest 0
  output logic [1:0]   out_tuser,  // [1:0] result_kind
  // configuration writes
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [47:0]  cfg_data
);

  ttw_pkg::cfg_t    cfg_r;
  ttw_pkg::item_t   load_item;
  ttw_pkg::item_t   item;
  ttw_pkg::result_t res;
  logic             item_valid;
  logic             take;
  logic             load;

  // Config registers; an index past the list is dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{granule_code: 2'd0, level_count: 3'd4, root_table_base: '0};
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ttw_pkg::CFG_GRANULE: cfg_r.granule_code    <= cfg_data[1:0];
        ttw_pkg::CFG_LEVELS:  cfg_r.level_count     <= cfg_data[2:0];
        ttw_pkg::CFG_ROOT:    cfg_r.root_table_base <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register is free when empty or draining into the result register.
  assign in_tready = !item_valid || take;
  assign load      = in_tvalid && in_tready;
  assign load_item = '{req_type: ttw_pkg::req_type_t'(in_tuser),
                       virt_addr: in_tdata[63:0],
                       descriptor: in_tdata[127:64]};

  ttw_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .load_item  (load_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  ttw_walk u_walk (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res        (res)
  );

  assign out_tdata = {5'd0, res.is_block, res.level, res.paddr};
  assign out_tuser = res.result_kind;

endmodule
